[rtl/ihfe_pkg.sv]
// ihfe_pkg: shared types, constants and the link framing lookup for the
// ipv4 header field extractor. No dependencies.
package ihfe_pkg;

  localparam int DEFAULT_LENGTH_BITS = 16;

  localparam logic [8:0] LINK_ETHERNET   = 9'd1;
  localparam logic [8:0] LINK_COOKED     = 9'd113;
  localparam logic [8:0] LINK_COOKED_V2  = 9'd276;
  localparam logic [8:0] LINK_RAW        = 9'd12;
  localparam logic [8:0] LINK_TYPE_RESET = LINK_ETHERNET;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_BAD_LINK    = 3'd1;
  localparam logic [2:0] STATUS_SHORT_LINK  = 3'd2;
  localparam logic [2:0] STATUS_NOT_IPV4    = 3'd3;
  localparam logic [2:0] STATUS_SHORT_IP    = 3'd4;
  localparam logic [2:0] STATUS_BAD_IHL     = 3'd5;

  localparam int RESULT_DATA_BITS = 112;

  typedef struct packed {
    logic [4:0] hdr_len;
    logic [4:0] et_off;
    logic       has_et;
    logic       ok;
  } framing_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  proto_number;
    logic [15:0] dest_port;
    logic [7:0]  time_to_live;
    logic [15:0] captured_length;
  } result_t;

  function automatic framing_t framing_of(input logic [8:0] lt);
    framing_t f;
    f = '0;
    case (lt)
      LINK_ETHERNET: begin
        f.hdr_len = 5'd14;
        f.et_off  = 5'd12;
        f.has_et  = 1'b1;
        f.ok      = 1'b1;
      end
      LINK_COOKED: begin
        f.hdr_len = 5'd16;
        f.et_off  = 5'd14;
        f.has_et  = 1'b1;
        f.ok      = 1'b1;
      end
      LINK_COOKED_V2: begin
        f.hdr_len = 5'd20;
        f.et_off  = 5'd0;
        f.has_et  = 1'b1;
        f.ok      = 1'b1;
      end
      LINK_RAW: begin
        f.ok = 1'b1;
      end
      default: begin
        f = '0;
      end
    endcase
    return f;
  endfunction

endpackage

[rtl/ihfe_parser.sv]
// ihfe_parser: per-packet byte counter and header field capture, and the
// result built on the last byte. Depends on ihfe_pkg.
module ihfe_parser #(
  parameter int LENGTH_BITS = ihfe_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [8:0]        link_code,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              res_valid,
  output ihfe_pkg::result_t res
);
  import ihfe_pkg::*;

  logic [LENGTH_BITS-1:0] byte_offset, byte_offset_next;
  logic [15:0] ethertype_seen, ethertype_seen_next;
  logic [3:0]  ip_header_words, ip_header_words_next;
  logic [7:0]  proto_seen, proto_seen_next;
  logic [7:0]  ttl_seen, ttl_seen_next;
  logic [31:0] src_seen, src_seen_next;
  logic [31:0] dst_seen, dst_seen_next;
  logic [15:0] port_seen, port_seen_next;

  framing_t               f;
  logic [LENGTH_BITS-1:0] pos, cap, hdr, ip_bytes, ihl_ext, l4;
  logic [6:0]             l4_narrow;
  logic [5:0]             ihl_bytes;
  logic [31:0]            cap32;
  logic [2:0]             status;

  always_comb begin
    f   = framing_of(link_code);
    pos = byte_offset;
    hdr = LENGTH_BITS'(f.hdr_len);

    ethertype_seen_next  = ethertype_seen;
    ip_header_words_next = ip_header_words;
    ttl_seen_next        = ttl_seen;
    proto_seen_next      = proto_seen;
    src_seen_next        = src_seen;
    dst_seen_next        = dst_seen;
    port_seen_next       = port_seen;

    if (f.ok) begin
      if (f.has_et && pos == LENGTH_BITS'(f.et_off))
        ethertype_seen_next[15:8] = in_byte;
      if (f.has_et && pos == LENGTH_BITS'({1'b0, f.et_off} + 6'd1))
        ethertype_seen_next[7:0] = in_byte;
      if (pos == hdr)
        ip_header_words_next = in_byte[3:0];
      if (pos == hdr + LENGTH_BITS'(8))
        ttl_seen_next = in_byte;
      if (pos == hdr + LENGTH_BITS'(9))
        proto_seen_next = in_byte;
      if (pos >= hdr + LENGTH_BITS'(12) && pos <= hdr + LENGTH_BITS'(15))
        src_seen_next = {src_seen[23:0], in_byte};
      if (pos >= hdr + LENGTH_BITS'(16) && pos <= hdr + LENGTH_BITS'(19))
        dst_seen_next = {dst_seen[23:0], in_byte};
    end

    // transport header start, using this byte's view of the ihl
    ihl_bytes = {ip_header_words_next, 2'b00};
    l4_narrow = {2'b00, f.hdr_len} + {1'b0, ihl_bytes};
    l4        = LENGTH_BITS'(l4_narrow);
    if (f.ok) begin
      if (pos == l4 + LENGTH_BITS'(2))
        port_seen_next[15:8] = in_byte;
      if (pos == l4 + LENGTH_BITS'(3))
        port_seen_next[7:0] = in_byte;
    end

    // byte count saturates at all ones
    cap = (pos == '1) ? pos : pos + LENGTH_BITS'(1);
    byte_offset_next = cap;

    ihl_ext  = LENGTH_BITS'(ihl_bytes);
    ip_bytes = cap - hdr;
    if (!f.ok)
      status = STATUS_BAD_LINK;
    else if (cap < hdr)
      status = STATUS_SHORT_LINK;
    else if (f.has_et && ethertype_seen_next != ETHERTYPE_IPV4)
      status = STATUS_NOT_IPV4;
    else if (ip_bytes < LENGTH_BITS'(20))
      status = STATUS_SHORT_IP;
    else if (ihl_bytes < 6'd20 || ihl_ext > ip_bytes)
      status = STATUS_BAD_IHL;
    else
      status = STATUS_OK;

    cap32 = 32'(cap);
    res = '0;
    res.status          = status;
    res.captured_length = (cap32 > 32'h0000_FFFF) ? 16'hFFFF : cap32[15:0];
    if (status == STATUS_OK) begin
      res.source_address = src_seen_next;
      res.dest_address   = dst_seen_next;
      res.proto_number   = proto_seen_next;
      res.time_to_live   = ttl_seen_next;
      res.dest_port      = 16'd1;
      if ((proto_seen_next == PROTO_TCP || proto_seen_next == PROTO_UDP) &&
          (ip_bytes - ihl_ext) >= LENGTH_BITS'(4))
        res.dest_port = port_seen_next;
    end

    res_valid = in_accept && in_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && in_last)) begin
      byte_offset     <= '0;
      ethertype_seen  <= '0;
      ip_header_words <= '0;
      proto_seen      <= '0;
      ttl_seen        <= '0;
      src_seen        <= '0;
      dst_seen        <= '0;
      port_seen       <= '0;
    end else if (in_accept) begin
      byte_offset     <= byte_offset_next;
      ethertype_seen  <= ethertype_seen_next;
      ip_header_words <= ip_header_words_next;
      proto_seen      <= proto_seen_next;
      ttl_seen        <= ttl_seen_next;
      src_seen        <= src_seen_next;
      dst_seen        <= dst_seen_next;
      port_seen       <= port_seen_next;
    end
  end

endmodule

[rtl/ipv4_header_field_extractor_core.sv]
// ipv4_header_field_extractor_core: the result of an accepted last byte is
// registered into a two-entry queue whose head drives m_tvalid. Throughput is
// one byte per cycle while s_tready is high, set by the single-pass capture
// logic in ihfe_parser. The queue lets bytes keep flowing while one result
// waits; s_tready drops only when both hold. Reset (rst, synchronous): link
// code back to ethernet, packet state cleared, queue empty.
module ipv4_header_field_extractor_core #(
  parameter int LENGTH_BITS = ihfe_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data,   // link code
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // pkt_byte
  input  logic         s_tlast,    // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // source_address[31:0], dest_address[63:32], proto_number[71:64],
  // dest_port[87:72], time_to_live[95:88], captured_length[111:96]
  output logic [ihfe_pkg::RESULT_DATA_BITS-1:0] m_tdata,
  output logic [2:0]   m_tuser     // status
);
  import ihfe_pkg::*;

  logic [8:0] link_code;
  logic       in_accept, res_valid, pop;
  result_t    res, head, tail;
  logic [1:0] count;

  assign cfg_ready = 1'b1;
  assign s_tready  = (count != 2'd2);
  assign in_accept = s_tvalid && s_tready;
  assign m_tvalid  = (count != 2'd0);
  assign pop       = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst)
      link_code <= LINK_TYPE_RESET;
    else if (cfg_valid && cfg_ready)
      link_code <= cfg_data;
  end

  ihfe_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .link_code (link_code),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-entry result queue, head drives the output
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({res_valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({res_valid, pop})
      2'b10: begin
        if (count == 2'd0)
          head <= res;
        else
          tail <= res;
      end
      2'b01: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head <= res;
        end else begin
          head <= tail;
          tail <= res;
        end
      end
      default: begin
        head <= head;
      end
    endcase
  end

  assign m_tuser = head.status;
  assign m_tdata = {head.captured_length, head.time_to_live, head.dest_port,
                    head.proto_number, head.dest_address, head.source_address};

endmodule
